/* sv/sdft_pkg.sv */
// Shared types, constants and trig table for the sliding DFT harmonic tracker.
// No dependencies; imported by every module of the block.
package sdft_pkg;

  localparam int unsigned CHANNELS_DEF    = 12;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned WINDOW          = 128;
  localparam int unsigned PH_W            = 7;
  localparam int unsigned NUM_HARM        = 4;
  localparam int unsigned DC_SHIFT        = 11;
  localparam int unsigned SQ_W            = 40;
  localparam int unsigned ACC_W           = 32;
  localparam int unsigned TRIG_W          = 14;
  localparam int unsigned CH_W            = 4;
  localparam int unsigned IN_W            = 16;

  localparam logic [PH_W-1:0] HARM_ORDER [NUM_HARM] = '{7'd1, 7'd3, 7'd5, 7'd7};

  // MAC step codes
  localparam logic [3:0] STEP_SQ_NEW = 4'd0;
  localparam logic [3:0] STEP_SQ_OLD = 4'd1;
  localparam logic [3:0] STEP_RES0   = 4'd2;
  localparam logic [3:0] STEP_LAST   = 4'd9;

  // Q12 quarter-wave cosine, entries 0..32
  localparam logic signed [TRIG_W-1:0] QUARTER_COS [33] = '{
    14'sd4096, 14'sd4091, 14'sd4076, 14'sd4051, 14'sd4017, 14'sd3973, 14'sd3919,
    14'sd3856, 14'sd3784, 14'sd3702, 14'sd3612, 14'sd3513, 14'sd3405, 14'sd3289,
    14'sd3166, 14'sd3034, 14'sd2896, 14'sd2750, 14'sd2598, 14'sd2439, 14'sd2275,
    14'sd2105, 14'sd1930, 14'sd1751, 14'sd1567, 14'sd1379, 14'sd1189, 14'sd995,
    14'sd799,  14'sd601,  14'sd401,  14'sd200,  14'sd0
  };

  typedef struct packed {
    logic [SQ_W-1:0]                    sq;
    logic [ACC_W-1:0]                   dc;
    logic [2*NUM_HARM-1:0][ACC_W-1:0]   res;
  } acc_t;

  typedef struct packed {
    acc_t                               acc;
    logic [NUM_HARM-1:0][PH_W-1:0]      ph;
  } chan_rec_t;

  typedef struct packed {
    logic       load;
    logic       issue;
    logic [3:0] step;
  } mac_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // floor of negated quarter-wave entry
  function automatic logic signed [TRIG_W-1:0] neg_entry(input logic [5:0] j);
    logic signed [TRIG_W-1:0] r;
    if (j == 6'd0) begin
      r = -14'sd4096;
    end else if (j >= 6'd32) begin
      r = 14'sd0;
    end else begin
      r = -(QUARTER_COS[j] + 14'sd1);
    end
    return r;
  endfunction

  function automatic logic signed [TRIG_W-1:0] cos_q12(input logic [PH_W-1:0] k);
    logic [7:0]               kk;
    logic signed [TRIG_W-1:0] r;
    kk = {1'b0, k};
    if (kk <= 8'd32) begin
      r = QUARTER_COS[kk[5:0]];
    end else if (kk <= 8'd64) begin
      r = neg_entry(6'(8'd64 - kk));
    end else if (kk <= 8'd96) begin
      r = neg_entry(6'(kk - 8'd64));
    end else begin
      r = QUARTER_COS[6'(8'd128 - kk)];
    end
    return r;
  endfunction

  function automatic logic signed [TRIG_W-1:0] sin_q12(input logic [PH_W-1:0] k);
    return cos_q12(k + 7'd96);
  endfunction

endpackage

/* sv/sdft_win_mem.sv */
// Per-channel sample window: one RAM of CHANNELS*WINDOW samples, write pointers
// and wrap flags. Uses sdft_pkg.
module sdft_win_mem #(
  parameter int unsigned CHANNELS    = sdft_pkg::CHANNELS_DEF,
  parameter int unsigned SAMPLE_BITS = sdft_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned CW          = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic                          wr_en_i,
  input  logic [CW-1:0]                 ch_i,
  input  logic signed [SAMPLE_BITS-1:0] wr_data_i,
  output logic signed [SAMPLE_BITS-1:0] rd_data_o
);
  import sdft_pkg::*;

  localparam int unsigned DEPTH = CHANNELS * WINDOW;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [SAMPLE_BITS-1:0] mem [DEPTH];
  logic [PH_W-1:0]        wp_q [CHANNELS];
  logic [CHANNELS-1:0]    full_q;
  logic [SAMPLE_BITS-1:0] rd_q;
  logic                   rd_full_q;
  logic [AW-1:0]          addr;

  assign addr = AW'({ch_i, wp_q[ch_i]});

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[addr] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[addr];
    end
  end

  // an entry is live once its channel has wrapped; before that it reads zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        wp_q[i] <= '0;
      end
      full_q    <= '0;
      rd_full_q <= 1'b0;
    end else begin
      if (rd_en_i) begin
        rd_full_q <= full_q[ch_i];
      end
      if (wr_en_i) begin
        wp_q[ch_i] <= wp_q[ch_i] + 1'b1;
        if (wp_q[ch_i] == PH_W'(WINDOW - 1)) begin
          full_q[ch_i] <= 1'b1;
        end
      end
    end
  end

  assign rd_data_o = rd_full_q ? signed'(rd_q) : '0;

endmodule

/* sv/sdft_state_mem.sv */
// Per-channel accumulator and phase record RAM with valid bits for reset-to-zero.
// Uses sdft_pkg.
module sdft_state_mem #(
  parameter int unsigned CHANNELS = sdft_pkg::CHANNELS_DEF,
  parameter int unsigned CW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_en_i,
  input  logic                  wr_en_i,
  input  logic [CW-1:0]         ch_i,
  input  sdft_pkg::chan_rec_t   wr_rec_i,
  output sdft_pkg::chan_rec_t   rd_rec_o
);
  import sdft_pkg::*;

  chan_rec_t           mem [CHANNELS];
  chan_rec_t           rd_q;
  logic [CHANNELS-1:0] valid_q;
  logic                rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[ch_i] <= wr_rec_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[ch_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (rd_en_i) begin
        rd_valid_q <= valid_q[ch_i];
      end
      if (wr_en_i) begin
        valid_q[ch_i] <= 1'b1;
      end
    end
  end

  assign rd_rec_o = rd_valid_q ? rd_q : '0;

endmodule

/* sv/sdft_mac.sv */
// Shared multiplier with registered product and the working accumulator set.
// Uses sdft_pkg.
module sdft_mac #(
  parameter int unsigned A_W = 17,
  parameter int unsigned B_W = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sdft_pkg::mac_ctrl_t   ctrl_i,
  input  sdft_pkg::acc_t        load_acc_i,
  input  logic signed [A_W-1:0] a_i,
  input  logic signed [B_W-1:0] b_i,
  output sdft_pkg::acc_t        acc_o
);
  import sdft_pkg::*;

  localparam int unsigned PW = A_W + B_W;

  logic signed [PW-1:0] prod_q;
  logic [63:0]          prod_ext;
  logic                 acc_en_q;
  logic [3:0]           step_q;
  logic [2:0]           res_idx;
  acc_t                 acc_q;

  assign prod_ext = {{(64-PW){prod_q[PW-1]}}, prod_q};
  assign res_idx  = 3'(step_q - STEP_RES0);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.issue) begin
      prod_q <= a_i * b_i;
      step_q <= ctrl_i.step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_en_q <= 1'b0;
    end else begin
      acc_en_q <= ctrl_i.issue;
    end
  end

  // odd resonator slots are imaginary parts: subtract
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      acc_q <= load_acc_i;
    end else if (acc_en_q) begin
      case (step_q)
        STEP_SQ_NEW: acc_q.sq <= acc_q.sq + prod_ext[SQ_W-1:0];
        STEP_SQ_OLD: acc_q.sq <= acc_q.sq - prod_ext[SQ_W-1:0];
        default: begin
          if (res_idx[0]) begin
            acc_q.res[res_idx] <= acc_q.res[res_idx] - prod_ext[ACC_W-1:0];
          end else begin
            acc_q.res[res_idx] <= acc_q.res[res_idx] + prod_ext[ACC_W-1:0];
          end
        end
      endcase
    end
  end

  assign acc_o = acc_q;

endmodule

/* sv/sliding_dft_harmonic_tracker.sv */
// Top level of the multichannel sliding DFT harmonic tracker.
// Uses sdft_pkg, sdft_win_mem, sdft_state_mem and sdft_mac.
//
// Each beat in carries one sample of one channel; each beat out reports that
// channel's window sum of squares, DC accumulator and the real/imaginary
// accumulators of harmonics 1, 3, 5 and 7 after the update. An item passes
// through these steps: read the window RAM and the channel record RAM, form
// the comb difference and advance the phases, run the products on the single
// shared multiplier (two squares, eight resonator products), drain the last
// product, and write back and load the output register. A one-beat input
// buffer takes the next sample while an item is in work, and the output
// register holds a finished beat while the next item runs. No clearing pass
// is needed after reset: window entries read as zero until their channel
// first wraps, and channel records carry valid bits. A channel number at or
// above CHANNELS leaves all state alone and reports zeros.
module sliding_dft_harmonic_tracker #(
  parameter int unsigned CHANNELS    = sdft_pkg::CHANNELS_DEF,
  parameter int unsigned SAMPLE_BITS = sdft_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [sdft_pkg::CH_W-1:0]            channel_i,
  input  logic signed [sdft_pkg::IN_W-1:0]     sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [sdft_pkg::CH_W-1:0]            chan_out_o,
  output logic signed [sdft_pkg::SQ_W-1:0]     sum_squares_o,
  output logic signed [sdft_pkg::ACC_W-1:0]    dc_sum_o,
  output logic signed [sdft_pkg::ACC_W-1:0]    h1_real_o,
  output logic signed [sdft_pkg::ACC_W-1:0]    h1_imag_o,
  output logic signed [sdft_pkg::ACC_W-1:0]    h3_real_o,
  output logic signed [sdft_pkg::ACC_W-1:0]    h3_imag_o,
  output logic signed [sdft_pkg::ACC_W-1:0]    h5_real_o,
  output logic signed [sdft_pkg::ACC_W-1:0]    h5_imag_o,
  output logic signed [sdft_pkg::ACC_W-1:0]    h7_real_o,
  output logic signed [sdft_pkg::ACC_W-1:0]    h7_imag_o
);
  import sdft_pkg::*;

  localparam int unsigned CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SB  = SAMPLE_BITS;
  localparam int unsigned A_W = SB + 1;
  localparam int unsigned B_W = (SB > TRIG_W) ? SB : TRIG_W;

  // input buffer
  logic                 buf_valid_q;
  logic [CH_W-1:0]      buf_ch_q;
  logic signed [SB-1:0] buf_s_q;
  logic signed [SB-1:0] s_in;

  // item registers
  state_e                        state_q, state_d;
  logic [3:0]                    cnt_q;
  logic [CH_W-1:0]               ch_q;
  logic                          bad_q;
  logic signed [SB-1:0]          s_q;
  logic signed [SB-1:0]          old_q;
  logic signed [A_W-1:0]         d_q;
  logic [NUM_HARM-1:0][PH_W-1:0] ph_q;

  // output register
  logic            out_valid_q;
  logic [CH_W-1:0] out_ch_q;
  acc_t            out_rec_q;

  // control
  logic      buf_take, bad_c, out_free, done_fire;
  logic      win_rd_en, win_wr_en, st_rd_en, st_wr_en, out_load;
  mac_ctrl_t mac_ctrl;
  logic [CW-1:0] mem_ch;

  // datapath
  logic signed [SB-1:0]     win_rd_data;
  logic signed [SB-1:0]     old_c;
  logic signed [A_W-1:0]    d_c;
  chan_rec_t                st_rd, st_wr;
  acc_t                     load_acc, mac_acc;
  logic signed [A_W-1:0]    op_a;
  logic signed [B_W-1:0]    op_b;
  logic [1:0]               hsel;
  logic signed [TRIG_W-1:0] trig;

  // low SAMPLE_BITS of the port are the sample; a wider SAMPLE_BITS zero-extends the port
  if (SB <= IN_W) begin : g_narrow
    assign s_in = sample_i[SB-1:0];
  end else begin : g_wide
    assign s_in = {{(SB-IN_W){1'b0}}, sample_i};
  end

  assign in_stall_o = buf_valid_q;
  assign bad_c      = {2'b00, buf_ch_q} >= 6'(CHANNELS);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign mem_ch     = (state_q == ST_IDLE) ? CW'(buf_ch_q) : CW'(ch_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
    end else if (in_valid_i && !buf_valid_q) begin
      buf_valid_q <= 1'b1;
    end else if (buf_take) begin
      buf_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !buf_valid_q) begin
      buf_ch_q <= channel_i;
      buf_s_q  <= s_in;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (buf_valid_q) state_d = bad_c ? ST_DONE : ST_LOAD;
      ST_LOAD:  state_d = ST_MUL;
      ST_MUL:   if (cnt_q == STEP_LAST) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    buf_take       = 1'b0;
    win_rd_en      = 1'b0;
    st_rd_en       = 1'b0;
    done_fire      = 1'b0;
    mac_ctrl.load  = 1'b0;
    mac_ctrl.issue = 1'b0;
    mac_ctrl.step  = cnt_q;
    case (state_q)
      ST_IDLE: begin
        buf_take  = buf_valid_q;
        win_rd_en = buf_valid_q && !bad_c;
        st_rd_en  = buf_valid_q && !bad_c;
      end
      ST_LOAD:  mac_ctrl.load  = 1'b1;
      ST_MUL:   mac_ctrl.issue = 1'b1;
      ST_DONE:  done_fire      = out_free;
      default: ;
    endcase
  end

  assign win_wr_en = done_fire && !bad_q;
  assign st_wr_en  = done_fire && !bad_q;
  assign out_load  = done_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      bad_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_LOAD) begin
        cnt_q <= '0;
      end else if (state_q == ST_MUL) begin
        cnt_q <= cnt_q + 4'd1;
      end
      if (buf_take) begin
        bad_q <= bad_c;
      end
    end
  end

  // difference and phase advance once both RAM reads land
  assign old_c = win_rd_data;
  assign d_c   = A_W'(s_q) - A_W'(old_c);

  always_comb begin
    load_acc    = st_rd.acc;
    load_acc.dc = st_rd.acc.dc + (ACC_W'(d_c) << DC_SHIFT);
  end

  always_ff @(posedge clk_i) begin
    if (buf_take) begin
      ch_q <= buf_ch_q;
      s_q  <= buf_s_q;
    end
    if (state_q == ST_LOAD) begin
      old_q <= old_c;
      d_q   <= d_c;
      for (int h = 0; h < NUM_HARM; h++) begin
        ph_q[h] <= st_rd.ph[h] + HARM_ORDER[h];
      end
    end
  end

  // multiplier operands: two squares, then real/imag per harmonic
  assign hsel = 2'((cnt_q - STEP_RES0) >> 1);
  assign trig = cnt_q[0] ? sin_q12(ph_q[hsel]) : cos_q12(ph_q[hsel]);

  always_comb begin
    case (cnt_q)
      STEP_SQ_NEW: begin
        op_a = A_W'(s_q);
        op_b = B_W'(s_q);
      end
      STEP_SQ_OLD: begin
        op_a = A_W'(old_q);
        op_b = B_W'(old_q);
      end
      default: begin
        op_a = d_q;
        op_b = B_W'(trig);
      end
    endcase
  end

  sdft_win_mem #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SB),
    .CW          (CW)
  ) u_win (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (win_rd_en),
    .wr_en_i   (win_wr_en),
    .ch_i      (mem_ch),
    .wr_data_i (s_q),
    .rd_data_o (win_rd_data)
  );

  assign st_wr.acc = mac_acc;
  assign st_wr.ph  = ph_q;

  sdft_state_mem #(
    .CHANNELS (CHANNELS),
    .CW       (CW)
  ) u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (st_rd_en),
    .wr_en_i  (st_wr_en),
    .ch_i     (mem_ch),
    .wr_rec_i (st_wr),
    .rd_rec_o (st_rd)
  );

  sdft_mac #(
    .A_W (A_W),
    .B_W (B_W)
  ) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (mac_ctrl),
    .load_acc_i (load_acc),
    .a_i        (op_a),
    .b_i        (op_b),
    .acc_o      (mac_acc)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ch_q  <= ch_q;
      out_rec_q <= bad_q ? '0 : mac_acc;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign chan_out_o    = out_ch_q;
  assign sum_squares_o = out_rec_q.sq;
  assign dc_sum_o      = out_rec_q.dc;
  assign h1_real_o     = out_rec_q.res[0];
  assign h1_imag_o     = out_rec_q.res[1];
  assign h3_real_o     = out_rec_q.res[2];
  assign h3_imag_o     = out_rec_q.res[3];
  assign h5_real_o     = out_rec_q.res[4];
  assign h5_imag_o     = out_rec_q.res[5];
  assign h7_real_o     = out_rec_q.res[6];
  assign h7_imag_o     = out_rec_q.res[7];

`ifndef SYNTHESIS
  a_out_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o)
    else $error("result beat not presented after load");

  a_buf_freed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_take |=> !in_stall_o)
    else $error("input buffer not freed after take");

  a_bad_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && bad_q) |-> (!win_wr_en && !st_wr_en))
    else $error("out-of-range channel wrote state");

  a_mul_valid_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> !bad_q)
    else $error("multiplier running on out-of-range channel");
`endif

endmodule
